// ----- sv/ugdw_pkg.sv -----
package ugdw_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_FIRST_CHAR     = 3'd0;
  localparam logic [2:0] REG_LAST_CHAR      = 3'd1;
  localparam logic [2:0] REG_EXT_PRESENT    = 3'd2;
  localparam logic [2:0] REG_EXT_FIRST_CHAR = 3'd3;
  localparam logic [2:0] REG_EXT_LAST_CHAR  = 3'd4;
  localparam logic [2:0] REG_GLYPH_WIDTH    = 3'd5;
  localparam logic [2:0] REG_SPACING        = 3'd6;
  localparam logic [2:0] REG_SCALE          = 3'd7;

  // Byte classes of UTF-8
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_C2     = 8'hC2;
  localparam logic [7:0] LEAD_C3     = 8'hC3;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] MASK_LEN2   = 8'hE0;
  localparam logic [7:0] LEAD_LEN2   = 8'hC0;
  localparam logic [7:0] MASK_LEN3   = 8'hF0;
  localparam logic [7:0] LEAD_LEN3   = 8'hE0;
  localparam logic [7:0] MASK_LEN4   = 8'hF8;
  localparam logic [7:0] LEAD_LEN4   = 8'hF0;

  localparam logic [14:0] WIDTH_MAX = 15'h7FFF;

  // Live configuration with the precomputed cell advances
  typedef struct packed {
    logic [7:0]  first_char;
    logic [7:0]  last_char;
    logic        ext_present;
    logic [7:0]  ext_first_char;
    logic [7:0]  ext_last_char;
    logic [16:0] step_full;  // (glyph_width + spacing) * scale
    logic [15:0] step_last;  // glyph_width * scale
  } cfg_t;

  // One decoded cell
  typedef struct packed {
    logic [7:0] glyph_index;
    logic       has_glyph;
    logic       is_extended;
    logic [2:0] bytes_used;
    logic       is_last;
  } cell_t;

  // Cells produced by one input byte; cell0 is the earlier one
  typedef struct packed {
    logic [1:0] count;
    cell_t      cell0;
    cell_t      cell1;
  } push_t;

endpackage

// ----- sv/ugdw_if.sv -----
interface ugdw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ugdw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  glyph_index;
  logic        has_glyph;
  logic        is_extended;
  logic [2:0]  bytes_used;
  logic [14:0] text_width;
  logic        is_last;
  modport source (output valid, output glyph_index, output has_glyph, output is_extended,
                  output bytes_used, output text_width, output is_last, input ready);
  modport sink (input valid, input glyph_index, input has_glyph, input is_extended,
                input bytes_used, input text_width, input is_last, output ready);
endinterface

interface ugdw_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/ugdw_cfg.sv -----
module ugdw_cfg
  import ugdw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ugdw_cfg_if.sink     cfg_ch,
  output cfg_t         cfg
);

  logic [7:0]  first_char_r, last_char_r, ext_first_char_r, ext_last_char_r;
  logic        ext_present_r;
  logic [7:0]  glyph_width_r, spacing_r, scale_r;
  logic [16:0] step_full_r;
  logic [15:0] step_last_r;
  logic [8:0]  pitch;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_char_r     <= 8'd32;
      last_char_r      <= 8'd126;
      ext_present_r    <= 1'b0;
      ext_first_char_r <= 8'd160;
      ext_last_char_r  <= 8'd255;
      glyph_width_r    <= 8'd5;
      spacing_r        <= 8'd1;
      scale_r          <= 8'd1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_FIRST_CHAR:     first_char_r     <= cfg_ch.data;
        REG_LAST_CHAR:      last_char_r      <= cfg_ch.data;
        REG_EXT_PRESENT:    ext_present_r    <= cfg_ch.data[0];
        REG_EXT_FIRST_CHAR: ext_first_char_r <= cfg_ch.data;
        REG_EXT_LAST_CHAR:  ext_last_char_r  <= cfg_ch.data;
        REG_GLYPH_WIDTH:    glyph_width_r    <= cfg_ch.data;
        REG_SPACING:        spacing_r        <= cfg_ch.data;
        REG_SCALE:          scale_r          <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign pitch = {1'b0, glyph_width_r} + {1'b0, spacing_r};

  // Register the products so the width adder sees no multiplier in its path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_full_r <= 17'd6;
      step_last_r <= 16'd5;
    end else begin
      step_full_r <= 17'(pitch) * 17'(scale_r);
      step_last_r <= 16'(glyph_width_r) * 16'(scale_r);
    end
  end

  assign cfg.first_char     = first_char_r;
  assign cfg.last_char      = last_char_r;
  assign cfg.ext_present    = ext_present_r;
  assign cfg.ext_first_char = ext_first_char_r;
  assign cfg.ext_last_char  = ext_last_char_r;
  assign cfg.step_full      = step_full_r;
  assign cfg.step_last      = step_last_r;

endmodule

// ----- sv/ugdw_front.sv -----
module ugdw_front
  import ugdw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ugdw_in_if.sink   in_ch,
  input  cfg_t      cfg,
  input  logic      q_room,
  output push_t     push
);

  logic       lead_waiting_r, lead_waiting_nxt;
  logic       lead_lsb_r, lead_lsb_nxt;
  logic [1:0] skip_r, skip_nxt;
  logic [2:0] seq_r, seq_nxt;

  logic       accept;
  logic [7:0] b;
  logic       eot;
  logic       fr_emit;
  cell_t      fr_cell;
  logic       fr_hold;
  logic [1:0] fr_skip;
  logic [1:0] skip_dec;
  logic [2:0] seq_inc;

  function automatic cell_t blank_cell(input logic [2:0] used, input logic last);
    cell_t r;
    r = '0;
    r.bytes_used = used;
    r.is_last = last;
    return r;
  endfunction

  // Map a code through the glyph ranges; two-byte code points try extended first
  function automatic cell_t glyph_cell(input logic [7:0] code, input logic two_byte,
                                       input logic last, input cfg_t c);
    cell_t r;
    logic  in_b, in_e;
    in_b = (code >= c.first_char) && (code <= c.last_char);
    in_e = c.ext_present && (code >= c.ext_first_char) && (code <= c.ext_last_char);
    r = blank_cell(two_byte ? 3'd2 : 3'd1, last);
    if (in_e && (two_byte || !in_b)) begin
      r.glyph_index = code - c.ext_first_char;
      r.has_glyph = 1'b1;
      r.is_extended = 1'b1;
    end else if (in_b) begin
      r.glyph_index = code - c.first_char;
      r.has_glyph = 1'b1;
    end
    return r;
  endfunction

  assign in_ch.ready = q_room;
  assign accept = in_ch.valid && q_room;
  assign b = in_ch.text_byte;
  assign eot = in_ch.end_of_text;
  assign skip_dec = skip_r - 2'd1;
  assign seq_inc = seq_r + 3'd1;

  // Decode a byte with nothing pending
  always_comb begin
    fr_emit = 1'b1;
    fr_hold = 1'b0;
    fr_skip = 2'd0;
    fr_cell = blank_cell(3'd1, eot);
    if (b < ASCII_LIMIT) begin
      fr_cell = glyph_cell(b, 1'b0, eot, cfg);
    end else if ((b == LEAD_C2) || (b == LEAD_C3)) begin
      if (!eot) begin
        fr_emit = 1'b0;
        fr_hold = 1'b1;
      end
    end else if (!eot) begin
      priority if ((b & MASK_LEN2) == LEAD_LEN2) begin
        fr_emit = 1'b0;
        fr_skip = 2'd1;
      end else if ((b & MASK_LEN3) == LEAD_LEN3) begin
        fr_emit = 1'b0;
        fr_skip = 2'd2;
      end else if ((b & MASK_LEN4) == LEAD_LEN4) begin
        fr_emit = 1'b0;
        fr_skip = 2'd3;
      end else begin
        fr_emit = 1'b1;
      end
    end
  end

  always_comb begin
    lead_waiting_nxt = lead_waiting_r;
    lead_lsb_nxt = lead_lsb_r;
    skip_nxt = skip_r;
    seq_nxt = seq_r;
    push.count = 2'd0;
    push.cell0 = blank_cell(3'd1, 1'b0);
    push.cell1 = blank_cell(3'd1, 1'b0);
    if (accept) begin
      if (skip_r != 2'd0) begin
        // Consume the byte whatever its value
        if ((skip_dec == 2'd0) || eot) begin
          push.count = 2'd1;
          push.cell0 = blank_cell(seq_inc, eot);
          skip_nxt = 2'd0;
          seq_nxt = 3'd0;
        end else begin
          skip_nxt = skip_dec;
          seq_nxt = seq_inc;
        end
      end else if (lead_waiting_r) begin
        lead_waiting_nxt = 1'b0;
        lead_lsb_nxt = 1'b0;
        if ((b >= CONT_MIN) && (b <= CONT_MAX)) begin
          push.count = 2'd1;
          push.cell0 = glyph_cell({1'b1, lead_lsb_r, b[5:0]}, 1'b1, eot, cfg);
        end else begin
          // Blank the lead, then decode the offending byte afresh
          push.count = fr_emit ? 2'd2 : 2'd1;
          push.cell0 = blank_cell(3'd1, 1'b0);
          push.cell1 = fr_cell;
          lead_waiting_nxt = fr_hold;
          lead_lsb_nxt = b[0];
          if (fr_skip != 2'd0) begin
            skip_nxt = fr_skip;
            seq_nxt = 3'd1;
          end
        end
      end else begin
        push.count = fr_emit ? 2'd1 : 2'd0;
        push.cell0 = fr_cell;
        lead_waiting_nxt = fr_hold;
        lead_lsb_nxt = b[0];
        if (fr_skip != 2'd0) begin
          skip_nxt = fr_skip;
          seq_nxt = 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_waiting_r <= 1'b0;
      lead_lsb_r <= 1'b0;
      skip_r <= 2'd0;
      seq_r <= 3'd0;
    end else begin
      lead_waiting_r <= lead_waiting_nxt;
      lead_lsb_r <= lead_lsb_nxt;
      skip_r <= skip_nxt;
      seq_r <= seq_nxt;
    end
  end

endmodule

// ----- sv/ugdw_queue.sv -----
module ugdw_queue
  import ugdw_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  pop_valid,
  input  logic  pop_ready,
  output cell_t pop_cell
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  cell_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_p1, wr_ptr_p2, rd_ptr_p1;
  logic [CntW-1:0] cnt_r;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);
  assign rd_ptr_p1 = ptr_inc(rd_ptr_r);

  // Keep room for the two cells one byte can produce
  assign room = cnt_r <= CntW'(DEPTH - 2);
  assign pop_valid = cnt_r != '0;
  assign pop = pop_valid && pop_ready;
  assign pop_cell = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.cell0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.cell1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      unique case (push.count)
        2'd1:    wr_ptr_r <= wr_ptr_p1;
        2'd2:    wr_ptr_r <= wr_ptr_p2;
        default: wr_ptr_r <= wr_ptr_r;
      endcase
      if (pop) begin
        rd_ptr_r <= rd_ptr_p1;
      end
      cnt_r <= cnt_r + CntW'(push.count) - CntW'(pop);
    end
  end

endmodule

// ----- sv/ugdw_back.sv -----
module ugdw_back
  import ugdw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  cell_t      pop_cell,
  ugdw_out_if.source out_ch
);

  logic        out_valid_r;
  cell_t       cell_r;
  logic [14:0] text_width_r;
  logic [14:0] width_sum_r, width_sum_nxt;
  logic [16:0] step;
  logic [17:0] sum;
  logic [14:0] sat;
  logic        take;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign take = pop_valid && pop_ready;

  // Last cell drops the trailing spacing
  assign step = pop_cell.is_last ? {1'b0, cfg.step_last} : cfg.step_full;
  assign sum = {3'b0, width_sum_r} + {1'b0, step};
  assign sat = (sum > {3'b0, WIDTH_MAX}) ? WIDTH_MAX : sum[14:0];
  assign width_sum_nxt = pop_cell.is_last ? 15'd0 : sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      width_sum_r <= 15'd0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        width_sum_r <= width_sum_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cell_r <= pop_cell;
      text_width_r <= sat;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.glyph_index = cell_r.glyph_index;
  assign out_ch.has_glyph   = cell_r.has_glyph;
  assign out_ch.is_extended = cell_r.is_extended;
  assign out_ch.bytes_used  = cell_r.bytes_used;
  assign out_ch.text_width  = text_width_r;
  assign out_ch.is_last     = cell_r.is_last;

endmodule

// ----- sv/utf8_glyph_decoder_width.sv -----
// UTF-8 glyph decoder with running text width.
// in_ch carries one text byte per transaction plus end_of_text on the last
// byte. out_ch carries one transaction per decoded cell: glyph index, glyph
// and extended flags, bytes used, running width and the last-cell flag; the
// last cell of a text carries the final width without the trailing spacing.
// cfg_ch writes the eight font registers by index; write it only while no
// text is in flight.
// A cell enters the cell queue when the byte that completes it is accepted,
// then moves to the output register. Throughput: one byte per cycle while the
// queue has room; a byte that closes a bad two-byte sequence gives two cells,
// which the queue absorbs while the output drains one cell per ready cycle.
// When the receiver stalls, the output register holds its cell, the queue
// fills, and in_ch.ready drops once fewer than two queue slots are free.
// Reset (synchronous, active low): restore register defaults, drop any
// pending sequence, empty the queue and clear the running width.
module utf8_glyph_decoder_width
  import ugdw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  ugdw_in_if.sink    in_ch,
  ugdw_out_if.source out_ch,
  ugdw_cfg_if.sink   cfg_ch
);

  cfg_t  cfg;
  push_t push;
  logic  q_room;
  logic  pop_valid;
  logic  pop_ready;
  cell_t pop_cell;

  // Register file and precomputed cell advances
  ugdw_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Front: split the byte stream into cells and map glyphs
  ugdw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_room (q_room),
    .push   (push)
  );

  // Decouple front and back so each side stalls on its own
  ugdw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (q_room),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cell  (pop_cell)
  );

  // Back: accumulate width and register the result
  ugdw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cell  (pop_cell),
    .out_ch    (out_ch)
  );

endmodule

// ----- verif/utf8_glyph_decoder_width_tb.sv -----
`timescale 1ns / 1ps

module utf8_glyph_decoder_width_tb;
  import ugdw_pkg::*;

  // One decoded cell as it should leave out_ch
  typedef struct {
    logic [7:0]  glyph_index;
    logic        has_glyph;
    logic        is_extended;
    logic [2:0]  bytes_used;
    logic [14:0] text_width;
    logic        is_last;
  } glyph_cell_t;

  logic clk;
  logic rst_n;

  ugdw_in_if  in_ch ();
  ugdw_out_if out_ch ();
  ugdw_cfg_if cfg_ch ();

  utf8_glyph_decoder_width u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the font registers, indexed by register number
  logic [7:0] font_reg [8];

  // Decoder state: held two-byte lead, bytes left to swallow in a longer
  // sequence, bytes seen so far in it, and the running width in pixels
  logic [7:0] lead_byte;
  bit         lead_pending;
  int         cont_left;
  int         seq_bytes;
  int         width_acc;

  // Cells predicted but not yet seen on out_ch, oldest first
  glyph_cell_t pending_cells [$];

  int error_count = 0;
  int bytes_sent  = 0;

  // Upper bound of the per-transaction idle draw on each side
  int in_max_gap    = 6;
  int out_max_stall = 6;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bail out if the run hangs; far beyond the slowest correct run
  initial begin
    #(4_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // ------------------------------------------------------------------
  // Glyph lookup and width accounting
  // ------------------------------------------------------------------

  function automatic bit base_hit(logic [7:0] c, output logic [7:0] idx);
    idx = c - font_reg[REG_FIRST_CHAR];
    return c >= font_reg[REG_FIRST_CHAR] && c <= font_reg[REG_LAST_CHAR];
  endfunction

  function automatic bit ext_hit(logic [7:0] c, output logic [7:0] idx);
    idx = c - font_reg[REG_EXT_FIRST_CHAR];
    return font_reg[REG_EXT_PRESENT][0] && c >= font_reg[REG_EXT_FIRST_CHAR] &&
           c <= font_reg[REG_EXT_LAST_CHAR];
  endfunction

  // Advance the running width by one cell and queue the cell. The last cell
  // of a text adds no trailing spacing and returns the decoder to rest.
  task automatic push_cell(logic [7:0] idx, bit has, bit ext, int used, bit last);
    glyph_cell_t c;
    int sum;
    if (last) begin
      sum = width_acc + int'(font_reg[REG_GLYPH_WIDTH]) * int'(font_reg[REG_SCALE]);
      c.text_width = (sum > int'(WIDTH_MAX)) ? WIDTH_MAX : 15'(sum);
      width_acc    = 0;
      lead_byte    = 8'd0;
      lead_pending = 1'b0;
      cont_left    = 0;
      seq_bytes    = 0;
    end else begin
      sum = width_acc + (int'(font_reg[REG_GLYPH_WIDTH]) + int'(font_reg[REG_SPACING])) *
            int'(font_reg[REG_SCALE]);
      width_acc    = (sum > int'(WIDTH_MAX)) ? int'(WIDTH_MAX) : sum;
      c.text_width = 15'(width_acc);
    end
    c.glyph_index = has ? idx : 8'd0;
    c.has_glyph   = has;
    c.is_extended = has & ext;
    c.bytes_used  = 3'(used);
    c.is_last     = last;
    pending_cells.push_back(c);
  endtask

  // Decode a byte with no sequence open
  task automatic decode_fresh(logic [7:0] b, bit eot);
    int len = 1;
    logic [7:0] idx;
    if (b < ASCII_LIMIT) begin
      // Single byte: base range wins over extended range
      if (base_hit(b, idx))     push_cell(idx, 1'b1, 1'b0, 1, eot);
      else if (ext_hit(b, idx)) push_cell(idx, 1'b1, 1'b1, 1, eot);
      else                      push_cell(8'd0, 1'b0, 1'b0, 1, eot);
    end else if (b == LEAD_C2 || b == LEAD_C3) begin
      // Latin-1 lead: hold it, or give a blank cell when the text ends here
      if (eot) push_cell(8'd0, 1'b0, 1'b0, 1, 1'b1);
      else begin
        lead_byte    = b;
        lead_pending = 1'b1;
      end
    end else begin
      if ((b & MASK_LEN2) == LEAD_LEN2)      len = 2;
      else if ((b & MASK_LEN3) == LEAD_LEN3) len = 3;
      else if ((b & MASK_LEN4) == LEAD_LEN4) len = 4;
      if (len == 1 || eot) push_cell(8'd0, 1'b0, 1'b0, 1, eot);
      else begin
        cont_left = len - 1;
        seq_bytes = 1;
      end
    end
  endtask

  // Work out the cells that one accepted byte produces
  task automatic decode_byte(logic [7:0] b, bit eot);
    logic [7:0] lead;
    logic [7:0] cp;
    logic [7:0] idx;
    int used;
    if (cont_left != 0) begin
      // Swallow the tail of a longer sequence whatever its value; a text end
      // cuts the cell short
      seq_bytes++;
      cont_left--;
      if (cont_left == 0 || eot) begin
        used      = seq_bytes;
        cont_left = 0;
        seq_bytes = 0;
        push_cell(8'd0, 1'b0, 1'b0, used, eot);
      end
    end else if (lead_pending) begin
      lead         = lead_byte;
      lead_pending = 1'b0;
      lead_byte    = 8'd0;
      if (b >= CONT_MIN && b <= CONT_MAX) begin
        // Two-byte code point: extended range wins over base range
        cp = {lead[1:0], b[5:0]};
        if (ext_hit(cp, idx))       push_cell(idx, 1'b1, 1'b1, 2, eot);
        else if (base_hit(cp, idx)) push_cell(idx, 1'b1, 1'b0, 2, eot);
        else                        push_cell(8'd0, 1'b0, 1'b0, 2, eot);
      end else begin
        // Bad continuation: blank cell for the lead, then decode b afresh
        push_cell(8'd0, 1'b0, 1'b0, 1, 1'b0);
        decode_fresh(b, eot);
      end
    end else begin
      decode_fresh(b, eot);
    end
  endtask

  // ------------------------------------------------------------------
  // Channel drivers
  // ------------------------------------------------------------------

  // Send one text byte. Leave valid high afterwards so that back-to-back
  // transactions need only one assignment per edge; drop it only for a gap.
  task automatic send_byte(logic [7:0] b, bit eot);
    int gap = $urandom_range(0, in_max_gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    decode_byte(b, eot);
    bytes_sent++;
  endtask

  // Send a whole text, flagging its last byte
  task automatic send_text(input logic [7:0] text [$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  // Stop sending and wait until every predicted cell has come out, then let
  // the pipeline settle; bounded so a lost cell cannot hang the run
  task automatic drain_cells();
    int waited = 0;
    in_ch.valid <= 1'b0;
    while (pending_cells.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write all eight font registers while the block is idle
  task automatic program_font(input logic [7:0] vals [8]);
    drain_cells();
    for (int i = 0; i < 8; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= 3'(i);
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      font_reg[i] = (3'(i) == REG_EXT_PRESENT) ? (vals[i] & 8'h01) : vals[i];
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly a value up to hi, now and then one of the byte extremes
  function automatic logic [7:0] pick_byte(int hi);
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic program_random_font();
    logic [7:0] vals [8];
    vals[REG_FIRST_CHAR]     = pick_byte(96);
    vals[REG_LAST_CHAR]      = pick_byte(255);
    vals[REG_EXT_PRESENT]    = ($urandom_range(0, 3) != 0) ? 8'd1 : 8'd0;
    vals[REG_EXT_FIRST_CHAR] = pick_byte(200);
    vals[REG_EXT_LAST_CHAR]  = pick_byte(255);
    vals[REG_GLYPH_WIDTH]    = pick_byte(12);
    vals[REG_SPACING]        = pick_byte(4);
    vals[REG_SCALE]          = pick_byte(4);
    program_font(vals);
  endtask

  // ------------------------------------------------------------------
  // Result side: random back-pressure and the cell checker
  // ------------------------------------------------------------------

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, out_max_stall);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Compare every accepted cell against the oldest prediction
  always @(posedge clk) begin : check_cells
    glyph_cell_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_cells.size() == 0) begin
        flag_error("cell arrived with none pending");
      end else begin
        want = pending_cells.pop_front();
        if (out_ch.glyph_index !== want.glyph_index || out_ch.has_glyph !== want.has_glyph ||
            out_ch.is_extended !== want.is_extended || out_ch.bytes_used !== want.bytes_used ||
            out_ch.text_width !== want.text_width || out_ch.is_last !== want.is_last) begin
          flag_error($sformatf({"cell mismatch: expected idx %0d glyph %0b ext %0b used %0d ",
                                "width %0d last %0b, got idx %0d glyph %0b ext %0b used %0d ",
                                "width %0d last %0b"},
                               want.glyph_index, want.has_glyph, want.is_extended,
                               want.bytes_used, want.text_width, want.is_last,
                               out_ch.glyph_index, out_ch.has_glyph, out_ch.is_extended,
                               out_ch.bytes_used, out_ch.text_width, out_ch.is_last));
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Reset font: ASCII extremes, stray bytes, Latin-1 pairs, longer leads,
  // bad continuations and texts that end inside a sequence
  task automatic test_default_font();
    // Below, at both ends of, and above the base range; strays 0x80 and 0xFF
    send_text('{8'h00, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF});
    // Latin-1 pair, then a C2 lead broken by an ASCII byte on the last byte
    send_text('{8'hC3, 8'hBF, 8'hC2, 8'h41});
    // Three-byte, four-byte and a non-Latin-1 two-byte lead
    send_text('{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC0, 8'hAF});
    // Three-byte sequence cut off by the end of text
    send_text('{8'hE2, 8'h82});
    // Lead alone on the last byte
    send_text('{8'hC2});
    // Lead broken by another lead that is itself the last byte
    send_text('{8'hC3, 8'hC3});
  endtask

  // Extended table on, overlapping the base range for ASCII
  task automatic test_extended_table();
    logic [7:0] vals [8];
    vals[REG_FIRST_CHAR]     = 8'h41;
    vals[REG_LAST_CHAR]      = 8'h5A;
    vals[REG_EXT_PRESENT]    = 8'd1;
    vals[REG_EXT_FIRST_CHAR] = 8'h20;
    vals[REG_EXT_LAST_CHAR]  = 8'hFE;
    vals[REG_GLYPH_WIDTH]    = 8'd8;
    vals[REG_SPACING]        = 8'd2;
    vals[REG_SCALE]          = 8'd3;
    program_font(vals);
    send_text('{8'h41, 8'h61, 8'hC3, 8'hBE, 8'hC3, 8'hBF, 8'hC2, 8'h80});
  endtask

  // Largest advances saturate the width; all-zero advances keep it at zero
  task automatic test_width_extremes();
    logic [7:0] vals [8];
    vals[REG_FIRST_CHAR]     = 8'h00;
    vals[REG_LAST_CHAR]      = 8'hFF;
    vals[REG_EXT_PRESENT]    = 8'd0;
    vals[REG_EXT_FIRST_CHAR] = 8'hA0;
    vals[REG_EXT_LAST_CHAR]  = 8'hFF;
    vals[REG_GLYPH_WIDTH]    = 8'hFF;
    vals[REG_SPACING]        = 8'hFF;
    vals[REG_SCALE]          = 8'hFF;
    program_font(vals);
    send_text('{8'h41, 8'h42, 8'h43});
    send_text('{8'h55});

    vals[REG_LAST_CHAR]      = 8'h00;
    vals[REG_EXT_PRESENT]    = 8'd1;
    vals[REG_EXT_FIRST_CHAR] = 8'h00;
    vals[REG_EXT_LAST_CHAR]  = 8'h00;
    vals[REG_GLYPH_WIDTH]    = 8'h00;
    vals[REG_SPACING]        = 8'h00;
    vals[REG_SCALE]          = 8'h00;
    program_font(vals);
    send_text('{8'h00, 8'hC2, 8'h80});
  endtask

  // Random fonts and texts built mostly from well-formed sequences with
  // random content, mixed with noise, broken pairs and cut-off tails
  task automatic test_random_texts();
    int stop_at = bytes_sent + 600;
    int texts;
    int pieces;
    int cut;
    logic [7:0] text [$];
    while (bytes_sent < stop_at) begin
      program_random_font();
      // Alternate busy stretches with stretches of random idling
      in_max_gap    = ($urandom_range(0, 3) == 0) ? 0 : 6;
      out_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 6;
      texts = $urandom_range(3, 8);
      repeat (texts) begin
        text.delete();
        pieces = $urandom_range(1, 8);
        repeat (pieces) begin
          case ($urandom_range(0, 11))
            0, 1, 2, 3: text.push_back(8'($urandom_range(0, 127)));
            4, 5: begin
              text.push_back(LEAD_C2 | 8'($urandom_range(0, 1)));
              text.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
            end
            6: begin
              text.push_back(LEAD_C2 | 8'($urandom_range(0, 1)));
              text.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127)) :
                             8'($urandom_range(8'hC0, 8'hFF)));
            end
            7: begin
              text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
              repeat (2) text.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
              text.push_back(8'($urandom_range(8'hF0, 8'hF7)));
              repeat (3) text.push_back(8'($urandom_range(0, 255)));
            end
            9: begin
              text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
              text.push_back(8'($urandom_range(0, 255)));
            end
            default: text.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        // Now and then chop the tail so the text ends inside a sequence
        if ($urandom_range(0, 3) == 0 && text.size() > 1) begin
          cut = $urandom_range(1, (text.size() > 2) ? 2 : 1);
          repeat (cut) void'(text.pop_back());
        end
        send_text(text);
      end
    end
    in_max_gap    = 6;
    out_max_stall = 6;
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin
    // Drive every input known from time zero and hold reset
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_FIRST_CHAR;
    cfg_ch.data       <= 8'h00;

    // Register defaults after reset
    font_reg[REG_FIRST_CHAR]     = 8'd32;
    font_reg[REG_LAST_CHAR]      = 8'd126;
    font_reg[REG_EXT_PRESENT]    = 8'd0;
    font_reg[REG_EXT_FIRST_CHAR] = 8'd160;
    font_reg[REG_EXT_LAST_CHAR]  = 8'd255;
    font_reg[REG_GLYPH_WIDTH]    = 8'd5;
    font_reg[REG_SPACING]        = 8'd1;
    font_reg[REG_SCALE]          = 8'd1;
    lead_byte    = 8'd0;
    lead_pending = 1'b0;
    cont_left    = 0;
    seq_bytes    = 0;
    width_acc    = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_default_font();
    test_extended_table();
    test_width_extremes();
    test_random_texts();

    // Let the last cells drain, then flag anything that never came out
    drain_cells();
    if (pending_cells.size() != 0)
      flag_error($sformatf("%0d predicted cells never arrived", pending_cells.size()));

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ugdw_pkg.sv
sv/ugdw_if.sv
sv/ugdw_cfg.sv
sv/ugdw_front.sv
sv/ugdw_queue.sv
sv/ugdw_back.sv
sv/utf8_glyph_decoder_width.sv
verif/utf8_glyph_decoder_width_tb.sv
